FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the flow color wheel checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define FVCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fvcw assertion failed");

// Clocked assertion, also checked during reset
`define FVCW_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fvcw assertion failed");

`endif

FILE: rtl/core/fvcw_pkg.sv
// ----------------------------------------------------------------------------
// fvcw_pkg
// Types and constant tables of the flow vector color wheel.
// ----------------------------------------------------------------------------
package fvcw_pkg;

  localparam int RY = 15;
  localparam int YG = 6;
  localparam int GC = 4;
  localparam int CB = 11;
  localparam int BM = 13;
  localparam int MR = 6;
  localparam int WHEEL_LEN = RY + YG + GC + CB + BM + MR;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS = 17;
  localparam logic [15:0] INV_RESET = 16'd256;
  localparam logic [23:0] FULL_SCALE = 24'(255 * 65536);

  // Arctangent of 2^-i in units of 2^-20 turn
  localparam logic [19:0] ATAN_TURNS [CORDIC_STEPS] = '{
    20'd131072, 20'd77376, 20'd40884, 20'd20753, 20'd10417, 20'd5213,
    20'd2607, 20'd1304, 20'd652, 20'd326, 20'd163, 20'd81, 20'd41,
    20'd20, 20'd10, 20'd5
  };

  // Wheel entries as {red, green, blue}
  localparam logic [23:0] WHEEL [WHEEL_LEN] = '{
    // red to yellow
    {8'd255, 8'd0, 8'd0}, {8'd255, 8'd17, 8'd0}, {8'd255, 8'd34, 8'd0},
    {8'd255, 8'd51, 8'd0}, {8'd255, 8'd68, 8'd0}, {8'd255, 8'd85, 8'd0},
    {8'd255, 8'd102, 8'd0}, {8'd255, 8'd119, 8'd0}, {8'd255, 8'd136, 8'd0},
    {8'd255, 8'd153, 8'd0}, {8'd255, 8'd170, 8'd0}, {8'd255, 8'd187, 8'd0},
    {8'd255, 8'd204, 8'd0}, {8'd255, 8'd221, 8'd0}, {8'd255, 8'd238, 8'd0},
    // yellow to green
    {8'd255, 8'd255, 8'd0}, {8'd213, 8'd255, 8'd0}, {8'd170, 8'd255, 8'd0},
    {8'd128, 8'd255, 8'd0}, {8'd85, 8'd255, 8'd0}, {8'd43, 8'd255, 8'd0},
    // green to cyan
    {8'd0, 8'd255, 8'd0}, {8'd0, 8'd255, 8'd63}, {8'd0, 8'd255, 8'd127},
    {8'd0, 8'd255, 8'd191},
    // cyan to blue
    {8'd0, 8'd255, 8'd255}, {8'd0, 8'd232, 8'd255}, {8'd0, 8'd209, 8'd255},
    {8'd0, 8'd186, 8'd255}, {8'd0, 8'd163, 8'd255}, {8'd0, 8'd140, 8'd255},
    {8'd0, 8'd116, 8'd255}, {8'd0, 8'd93, 8'd255}, {8'd0, 8'd70, 8'd255},
    {8'd0, 8'd47, 8'd255}, {8'd0, 8'd24, 8'd255},
    // blue to magenta
    {8'd0, 8'd0, 8'd255}, {8'd19, 8'd0, 8'd255}, {8'd39, 8'd0, 8'd255},
    {8'd58, 8'd0, 8'd255}, {8'd78, 8'd0, 8'd255}, {8'd98, 8'd0, 8'd255},
    {8'd117, 8'd0, 8'd255}, {8'd137, 8'd0, 8'd255}, {8'd156, 8'd0, 8'd255},
    {8'd176, 8'd0, 8'd255}, {8'd196, 8'd0, 8'd255}, {8'd215, 8'd0, 8'd255},
    {8'd235, 8'd0, 8'd255},
    // magenta to red
    {8'd255, 8'd0, 8'd255}, {8'd255, 8'd0, 8'd213}, {8'd255, 8'd0, 8'd170},
    {8'd255, 8'd0, 8'd128}, {8'd255, 8'd0, 8'd85}, {8'd255, 8'd0, 8'd43}
  };

  // State of one pixel inside the angle/radius pipeline
  typedef struct packed {
    logic               valid;
    logic               flow_valid;
    logic               zero_inv;
    logic               in_circle;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic [19:0]        z;
    logic [18:0]        rem;
    logic [16:0]        root;
    logic [33:0]        radicand;
  } fvcw_iter_t;

endpackage

FILE: rtl/core/fvcw_in_if.sv
// ----------------------------------------------------------------------------
// fvcw_in_if
// Flow vector channel: valid/ready handshake with one vector per transaction.
// ----------------------------------------------------------------------------
interface fvcw_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] flow_x;
  logic signed [15:0] flow_y;
  logic               flow_valid;

  modport source (output valid, flow_x, flow_y, flow_valid, input ready);
  modport sink (input valid, flow_x, flow_y, flow_valid, output ready);
endinterface

FILE: rtl/core/fvcw_out_if.sv
// ----------------------------------------------------------------------------
// fvcw_out_if
// Pixel color channel: valid/ready handshake with one BGR pixel per transaction.
// ----------------------------------------------------------------------------
interface fvcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

FILE: rtl/core/flow_vector_color_wheel_unit.sv
// ----------------------------------------------------------------------------
// flow_vector_color_wheel_unit
// Optical-flow vector to BGR color, wheel coding of direction and magnitude.
// ----------------------------------------------------------------------------
// Takes one flow vector per clock while the output is not stalled and returns
// one pixel per vector, in order: scaling and squaring registers, seventeen
// stages that each run one square-root digit and, but for the last, one CORDIC
// rotation, then wheel lookup, blending and shading up to the output register.
// The whole pipeline advances together; it halts only while a finished pixel
// sits in the output register unread. The scale register cfg_data (unsigned
// Q0.16 reciprocal of the maximum motion) resets to 1/256; the user must write
// it only while no transaction is in flight, which the block does not enforce.
module flow_vector_color_wheel_unit (
  input  logic        clk,
  input  logic        rst_n,
  fvcw_in_if.sink     in_ch,
  fvcw_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import fvcw_pkg::*;

  logic        en;
  logic [15:0] inv_r;
  logic        out_valid;
  fvcw_iter_t  stage [SQRT_STEPS + 1];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_RESET;
    end else if (cfg_we) begin
      inv_r <= cfg_data;
    end
  end

  // Advance unless the output register is full and stalled
  assign en           = !out_valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid;

  fvcw_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_take       (in_ch.valid),
    .in_flow_x     (in_ch.flow_x),
    .in_flow_y     (in_ch.flow_y),
    .in_flow_valid (in_ch.flow_valid),
    .inv_radius    (inv_r),
    .q             (stage[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    fvcw_step #(.STEP(i)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (stage[i]),
      .q     (stage[i + 1])
    );
  end

  fvcw_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .d         (stage[SQRT_STEPS]),
    .out_valid (out_valid),
    .out_blue  (out_ch.blue),
    .out_green (out_ch.green),
    .out_red   (out_ch.red)
  );

endmodule

FILE: rtl/core/fvcw_scale.sv
// ----------------------------------------------------------------------------
// fvcw_scale
// Three stages: scale by the inverse radius, square, sum and range check.
// Also prepares the half-plane fold of the angle rotator.
// ----------------------------------------------------------------------------
module fvcw_scale (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_take,
  input  logic signed [15:0]       in_flow_x,
  input  logic signed [15:0]       in_flow_y,
  input  logic                     in_flow_valid,
  input  logic [15:0]              inv_radius,
  output fvcw_pkg::fvcw_iter_t     q
);
  import fvcw_pkg::*;

  fvcw_iter_t         a_r, a_nxt;
  fvcw_iter_t         b_r;
  fvcw_iter_t         c_nxt, c_r;
  logic signed [31:0] sx_r, sy_r;
  logic signed [32:0] prod_x, prod_y;
  logic [61:0]        sqx_r, sqy_r;
  logic signed [63:0] sq_x, sq_y;
  logic [62:0]        r2;
  logic signed [35:0] x_ext, y_ext;

  // Scale and fold into the right half plane
  always_comb begin
    prod_x = 33'(in_flow_x) * 33'($signed({1'b0, inv_radius}));
    prod_y = 33'(in_flow_y) * 33'($signed({1'b0, inv_radius}));
    x_ext  = {{4{in_flow_x[15]}}, in_flow_x, 16'd0};
    y_ext  = {{4{in_flow_y[15]}}, in_flow_y, 16'd0};
    a_nxt            = '0;
    a_nxt.valid      = in_take;
    a_nxt.flow_valid = in_flow_valid;
    a_nxt.zero_inv   = (inv_radius == 16'd0);
    if (in_flow_x[15]) begin
      a_nxt.x = -x_ext;
      a_nxt.y = -y_ext;
      a_nxt.z = 20'h80000;
    end else begin
      a_nxt.x = x_ext;
      a_nxt.y = y_ext;
      a_nxt.z = 20'd0;
    end
  end

  // Square the scaled components
  always_comb begin
    sq_x = sx_r * sx_r;
    sq_y = sy_r * sy_r;
  end

  // Sum and compare against the unit circle
  always_comb begin
    r2              = 63'(sqx_r) + 63'(sqy_r);
    c_nxt           = b_r;
    c_nxt.in_circle = (r2 <= 63'h1_0000_0000);
    c_nxt.radicand  = r2[33:0];
    c_nxt.rem       = '0;
    c_nxt.root      = '0;
  end

  // Advance the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
      b_r.valid <= 1'b0;
      c_r.valid <= 1'b0;
    end else if (en) begin
      a_r   <= a_nxt;
      sx_r  <= prod_x[31:0];
      sy_r  <= prod_y[31:0];
      b_r   <= a_r;
      sqx_r <= sq_x[61:0];
      sqy_r <= sq_y[61:0];
      c_r   <= c_nxt;
    end
  end

  assign q = c_r;

endmodule

FILE: rtl/core/fvcw_step.sv
// ----------------------------------------------------------------------------
// fvcw_step
// One pipeline stage: one digit of the radius square root and, for STEP below
// CORDIC_STEPS, one rotation of the angle CORDIC.
// ----------------------------------------------------------------------------
module fvcw_step #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  fvcw_pkg::fvcw_iter_t d,
  output fvcw_pkg::fvcw_iter_t q
);
  import fvcw_pkg::*;

  localparam logic [19:0] ATAN_STEP = ATAN_TURNS[STEP % CORDIC_STEPS];

  fvcw_iter_t  q_r, q_nxt;
  logic [20:0] rem_sh;
  logic [20:0] trial;

  always_comb begin
    q_nxt = d;

    // Rotate toward the x axis; a vector on the axis stays put
    if (STEP < CORDIC_STEPS) begin
      if (!d.y[35] && (d.y != '0)) begin
        q_nxt.x = d.x + (d.y >>> STEP);
        q_nxt.y = d.y - (d.x >>> STEP);
        q_nxt.z = d.z + ATAN_STEP;
      end else if (d.y[35]) begin
        q_nxt.x = d.x - (d.y >>> STEP);
        q_nxt.y = d.y + (d.x >>> STEP);
        q_nxt.z = d.z - ATAN_STEP;
      end
    end

    // Restoring square root digit
    rem_sh = {d.rem, d.radicand[33:32]};
    trial  = {2'b00, d.root, 2'b01};
    q_nxt.radicand = {d.radicand[31:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = 19'(rem_sh - trial);
      q_nxt.root = {d.root[15:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh[18:0];
      q_nxt.root = {d.root[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/core/fvcw_color.sv
// ----------------------------------------------------------------------------
// fvcw_color
// Wheel lookup, interpolation, radius shading and the output register.
// ----------------------------------------------------------------------------
module fvcw_color (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  fvcw_pkg::fvcw_iter_t d,
  output logic                 out_valid,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_green,
  output logic [7:0]           out_red
);
  import fvcw_pkg::*;

  // Stage D: wheel position and table entries
  logic        d_valid_r, d_fv_r, d_in_r;
  logic [16:0] d_rad_r;
  logic [15:0] d_f_r;
  logic [23:0] d_w0_r, d_w1_r;
  logic [19:0] u;
  logic [25:0] p;
  logic [5:0]  k0, k1;

  // Stage E: interpolated channels
  logic        e_valid_r, e_fv_r, e_in_r;
  logic [16:0] e_rad_r;
  logic [23:0] e_c_r [3];
  logic [24:0] c_nxt [3];
  logic [16:0] f_inv;

  // Stage F: shading products
  logic        f_valid_r, f_fv_r, f_in_r;
  logic [23:0] f_c_r [3];
  logic [40:0] f_m_r [3];
  logic [40:0] m_nxt [3];

  // Stage G: output bytes
  logic        out_valid_r;
  logic [7:0]  byte_r [3];
  logic [7:0]  byte_nxt [3];
  logic [23:0] shade [3];
  logic [25:0] dim [3];

  always_comb begin
    u  = d.zero_inv ? 20'd0 : d.z;
    p  = 26'(u) * 26'(WHEEL_LEN - 1);
    k0 = p[25:20];
    k1 = k0 + 6'd1;
  end

  // Blend neighbouring entries, channel 2 = red, 1 = green, 0 = blue
  always_comb begin
    f_inv = 17'h10000 - 17'(d_f_r);
    for (int ch = 0; ch < 3; ch++) begin
      c_nxt[ch] = 25'(f_inv) * 25'(d_w0_r[8*ch +: 8])
                + 25'(d_f_r) * 25'(d_w1_r[8*ch +: 8]);
      m_nxt[ch] = 41'(e_rad_r) * 41'(FULL_SCALE - e_c_r[ch]);
    end
  end

  // Blend toward white inside the circle, dim to 3/4 outside, black if invalid
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      shade[ch] = FULL_SCALE - f_m_r[ch][39:16];
      dim[ch]   = 26'(f_c_r[ch]) * 26'd3;
      if (!f_fv_r) begin
        byte_nxt[ch] = 8'd0;
      end else if (f_in_r) begin
        byte_nxt[ch] = shade[ch][23:16];
      end else begin
        byte_nxt[ch] = dim[ch][25:18];
      end
    end
  end

  // Hold control under reset, advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r   <= d.valid;
      e_valid_r   <= d_valid_r;
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      d_fv_r  <= d.flow_valid;
      d_in_r  <= d.in_circle;
      d_rad_r <= d.root;
      d_f_r   <= p[19:4];
      d_w0_r  <= WHEEL[k0];
      d_w1_r  <= WHEEL[k1];
      e_fv_r  <= d_fv_r;
      e_in_r  <= d_in_r;
      e_rad_r <= d_rad_r;
      f_fv_r  <= e_fv_r;
      f_in_r  <= e_in_r;
      for (int ch = 0; ch < 3; ch++) begin
        e_c_r[ch]  <= c_nxt[ch][23:0];
        f_c_r[ch]  <= e_c_r[ch];
        f_m_r[ch]  <= m_nxt[ch];
        byte_r[ch] <= byte_nxt[ch];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = byte_r[0];
  assign out_green = byte_r[1];
  assign out_red   = byte_r[2];

endmodule

FILE: rtl/core/fvcw_checker.sv
// ----------------------------------------------------------------------------
// fvcw_checker
// Port-level checks of the color wheel unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fvcw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blue,
  input logic [7:0] out_green,
  input logic [7:0] out_red
);

  logic [23:0] out_color;

  assign out_color = {out_blue, out_green, out_red};

  // A stalled pixel stays offered
  `FVCW_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // A stalled pixel keeps its color
  `FVCW_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_color))

  // An empty output register never blocks the input
  `FVCW_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)

  // Reset drains the output
  `FVCW_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind flow_vector_color_wheel_unit fvcw_checker u_fvcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_blue  (out_ch.blue),
  .out_green (out_ch.green),
  .out_red   (out_ch.red)
);

FILE: sim/tb_flow_vector_color_wheel_unit.sv
// ----------------------------------------------------------------------------
// tb_flow_vector_color_wheel_unit
// Self-checking bench for the flow vector color wheel unit.
// ----------------------------------------------------------------------------
// Flow vectors stream in with random gaps, and colors drain with random stalls
// and one long hold-off. Each accepted vector is run through a bit-exact color
// predictor. Each pixel that comes out is compared against the oldest predicted
// color. The scale register is swept over several values between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_flow_vector_color_wheel_unit;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam longint FULL = 255 * 65536;

  // Level of one channel of wheel entry k: 0 red, 1 green, 2 blue
  function automatic longint wheel_level(int k, int ch);
    int i;
    longint r, g, b;
    if (k < 15) begin
      i = k; r = 255; g = 255 * i / 15; b = 0;
    end else if (k < 21) begin
      i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
    end else if (k < 25) begin
      i = k - 21; r = 0; g = 255; b = 255 * i / 4;
    end else if (k < 36) begin
      i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
    end else if (k < 49) begin
      i = k - 36; r = 255 * i / 13; g = 0; b = 255;
    end else begin
      i = (k - 49) % 6; r = 255; g = 0; b = 255 - 255 * i / 6;
    end
    return ch == 0 ? r : (ch == 1 ? g : b);
  endfunction

  // Expected color of one flow vector under a given scale
  function automatic pixel_t color_of(logic signed [15:0] fx, logic signed [15:0] fy,
                                      logic fv, logic [15:0] scale);
    pixel_t px;
    longint sx, sy, ax, ay, nx, ny, z;
    logic [63:0] r2, rad, t, p, f, c, shade;
    longint atan_step [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                               652, 326, 163, 81, 41, 20, 10, 5};
    logic [19:0] u;
    logic in_circle;
    int k0, k1;
    px = '{8'd0, 8'd0, 8'd0};
    if (!fv) return px;
    sx = longint'(fx) * longint'(scale);
    sy = longint'(fy) * longint'(scale);
    r2 = 64'(sx * sx) + 64'(sy * sy);
    in_circle = r2 <= 64'h1_0000_0000;
    rad = 0;
    if (in_circle) begin
      for (int b = 16; b >= 0; b--) begin
        t = rad | (64'd1 << b);
        if (t * t <= r2) rad = t;
      end
    end
    // Direction by CORDIC, first folded into the right half plane
    u = '0;
    if (scale != 0) begin
      ax = longint'(fx) * 65536;
      ay = longint'(fy) * 65536;
      z = 0;
      if (ax < 0) begin
        ax = -ax; ay = -ay; z = 524288;
      end
      for (int i = 0; i < 16 && ay != 0; i++) begin
        if (ay > 0) begin
          nx = ax + (ay >>> i); ny = ay - (ax >>> i); z += atan_step[i];
        end else begin
          nx = ax - (ay >>> i); ny = ay + (ax >>> i); z -= atan_step[i];
        end
        ax = nx; ay = ny;
      end
      u = z[19:0];
    end
    p = 64'(u) * 54;
    k0 = int'(p >> 20);
    if (k0 >= 55) k0 = 54;
    k1 = (k0 + 1 >= 55) ? 0 : k0 + 1;
    f = (p & 64'hFFFFF) >> 4;
    for (int ch = 0; ch < 3; ch++) begin
      c = (64'd65536 - f) * 64'(wheel_level(k0, ch)) + f * 64'(wheel_level(k1, ch));
      if (in_circle) shade = (64'(FULL) - ((rad * (64'(FULL) - c)) >> 16)) >> 16;
      else shade = (64'd3 * c) >> 18;
      case (ch)
        0: px.red = shade[7:0];
        1: px.green = shade[7:0];
        default: px.blue = shade[7:0];
      endcase
    end
    return px;
  endfunction

  // Holds predicted colors in order and compares drained pixels
  class color_scoreboard;
    pixel_t      pending_colors[$];
    logic [15:0] scale = 16'd256;
    int          errors = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_vector(logic signed [15:0] fx, logic signed [15:0] fy, logic fv);
      pending_colors.push_back(color_of(fx, fy, fv, scale));
    endfunction

    task check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      pixel_t want;
      if (pending_colors.size() == 0) begin
        report($sformatf("unexpected pixel b=%0d g=%0d r=%0d", b, g, r));
        return;
      end
      want = pending_colors.pop_front();
      if (b !== want.blue) report($sformatf("blue %0d, want %0d", b, want.blue));
      if (g !== want.green) report($sformatf("green %0d, want %0d", g, want.green));
      if (r !== want.red) report($sformatf("red %0d, want %0d", r, want.red));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          cycle_count;
  int          pixels_seen;
  bit          drain_idle;
  bit          feed_idle;
  color_scoreboard sb;

  fvcw_in_if  in_ch ();
  fvcw_out_if out_ch ();

  flow_vector_color_wheel_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drain pixels with random stalls and one long hold-off
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!held && pixels_seen >= 300) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = drain_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_pixel(out_ch.blue, out_ch.green, out_ch.red);
      pixels_seen++;
    end
  end

  // Offer one vector and hold it until taken
  task send_vector(logic signed [15:0] fx, logic signed [15:0] fy, logic fv);
    int gap;
    gap = feed_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.flow_x <= fx;
    in_ch.flow_y <= fy;
    in_ch.flow_valid <= fv;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_vector(fx, fy, fv);
  endtask

  // Wait for the pipeline to empty, then write the scale
  task write_scale(logic [15:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.scale = value;
  endtask

  // Random vectors, mostly near the unit circle of the current scale
  task random_vectors(int count);
    int reach;
    logic signed [15:0] fx, fy;
    reach = (sb.scale == 0) ? 32767 : 2 * 65536 / sb.scale + 1;
    if (reach > 32767) reach = 32767;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        feed_idle = $urandom_range(0, 3) != 0;
        drain_idle = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        fx = 16'($urandom);
        fy = 16'($urandom);
      end else begin
        fx = 16'($signed($urandom_range(0, 2 * reach)) - reach);
        fy = 16'($signed($urandom_range(0, 2 * reach)) - reach);
      end
      send_vector(fx, fy, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    logic [15:0] scales [6] = '{16'd1, 16'd65535, 16'd0, 16'd128, 16'd4096, 16'd300};
    sb = new();
    cycle_count = 0;
    pixels_seen = 0;
    feed_idle = 1'b1;
    drain_idle = 1'b1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= 16'd0;
    in_ch.valid <= 1'b0;
    in_ch.flow_x <= 16'sd0;
    in_ch.flow_y <= 16'sd0;
    in_ch.flow_valid <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vectors at the reset scale
    send_vector(16'sd0, 16'sd0, 1'b1);
    send_vector(16'sd256, 16'sd0, 1'b1);
    send_vector(16'sd1, 16'sd0, 1'b1);
    send_vector(-16'sd1, 16'sd0, 1'b1);
    send_vector(16'sd0, 16'sd1, 1'b1);
    send_vector(16'sd0, -16'sd1, 1'b1);
    send_vector(16'sd0, 16'sd256, 1'b1);
    send_vector(-16'sd256, 16'sd0, 1'b1);
    send_vector(16'sd0, -16'sd256, 1'b1);
    send_vector(16'sd181, 16'sd181, 1'b1);
    send_vector(16'sd100, -16'sd50, 1'b1);
    send_vector(-16'sd200, 16'sd120, 1'b1);
    send_vector(16'sd32767, 16'sd0, 1'b1);
    send_vector(-16'sd32768, 16'sd0, 1'b1);
    send_vector(16'sd0, 16'sd32767, 1'b1);
    send_vector(16'sd0, -16'sd32768, 1'b1);
    send_vector(16'sd32767, 16'sd32767, 1'b1);
    send_vector(-16'sd32768, -16'sd32768, 1'b1);
    send_vector(16'sd32767, -16'sd32768, 1'b0);
    send_vector(16'sd0, 16'sd0, 1'b0);
    send_vector(16'($urandom), 16'($urandom), 1'b0);
    random_vectors(400);

    // Sweep the scale, extremes and zero included
    foreach (scales[i]) begin
      write_scale(scales[i]);
      send_vector(16'sd32767, 16'sd1, 1'b1);
      send_vector(-16'sd32768, -16'sd32768, 1'b1);
      random_vectors(100);
    end
    write_scale(16'($urandom_range(1, 65535)));
    random_vectors(80);

    // Drain and settle
    in_ch.valid <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.pending_colors.size() != 0) sb.report("colors never drained");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
